@@ design/cab_pkg.sv @@
// ----------------------------------------------------------------------------
// cab_pkg: shared types, constants and arithmetic helpers
// Pixel and channel types, the divide-by-255 helper and one step
// of the restoring divider used to renormalize source alpha.
// ----------------------------------------------------------------------------
`default_nettype none

package cab_pkg;

	typedef logic [31:0] pixel_t;
	typedef logic [7:0]  chan_t;
	typedef logic [15:0] prod_t;

	localparam chan_t ALPHA_MAX = 8'hFF;

	// fields carried along the pipe from stage 3 onward
	typedef struct packed {
		logic        opaque;
		chan_t       sa;
		chan_t       fa;
		logic [23:0] dest_bgr;
	} ctx_t;

	// divider state: partial remainder and quotient bits so far
	typedef struct packed {
		prod_t rem;
		chan_t quo;
	} div_t;

	// x / 255 rounded down, exact for x up to 255*255
	function automatic chan_t d255(input prod_t x);
		logic [16:0] t;
		logic [16:0] u;
		t = 17'(x) + 17'd255;
		u = {8'b0, t[16:8]} + 17'(x);
		return u[15:8];
	endfunction

	// two quotient bits, hi and hi-1
	function automatic div_t div2(input div_t d, input chan_t fa, input logic [2:0] hi);
		div_t        r;
		prod_t       dv;
		logic [2:0]  b;
		r = d;
		for (int k = 0; k < 2; k++) begin
			b  = hi - 3'(k);
			dv = prod_t'(fa) << b;
			if (r.rem >= dv) begin
				r.rem    = r.rem - dv;
				r.quo[b] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/coverage_alpha_blend_bgra32_top.sv @@
// ----------------------------------------------------------------------------
// coverage_alpha_blend_bgra32_top: coverage-weighted source-over pixel blend
// Blends the paint color, scaled by per-pixel coverage, onto a
// non-premultiplied BGRA destination pixel.
// ----------------------------------------------------------------------------
// Takes one pixel request per cycle while the output side does not stall. The
// pipe has nine register stages: coverage times paint alpha, source alpha and
// destination weight, result alpha, a four-stage restoring divider (two quotient
// bits a stage) that renormalizes source alpha, channel products, and the final
// divide by 255 into the output register. A stall at the output holds the whole
// pipe; in_ready is low only while a result waits and out_ready is low. The
// paint color is written through the cfg channel, which is always ready, and
// must only change while no requests are in flight.
`default_nettype none

module coverage_alpha_blend_bgra32_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire cab_pkg::pixel_t  paint_color,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire cab_pkg::pixel_t  dest_pixel,
	input  wire cab_pkg::chan_t   coverage,
	output logic                  out_valid,
	input  wire                   out_ready,
	output cab_pkg::pixel_t       blended_pixel
);
	import cab_pkg::*;

	pixel_t paint_color_q;
	logic   en;

	logic   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic   valid_s6, valid_s7, valid_s8, valid_s9;

	// stage 1
	pixel_t dest_s1;
	logic   opaque_s1;
	prod_t  prod_s1;
	// stage 2
	logic        opaque_s2;
	chan_t       sa_s2;
	prod_t       wt_s2;
	logic [23:0] dest_bgr_s2;
	// stages 3..7
	ctx_t  ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7;
	div_t  div_s3, div_s4, div_s5, div_s6, div_s7;
	// stage 8
	logic  opaque_s8;
	chan_t fa_s8;
	prod_t ps_b_s8, ps_g_s8, ps_r_s8;
	prod_t pd_b_s8, pd_g_s8, pd_r_s8;
	// stage 9
	pixel_t out_s9;

	chan_t sa2_c;
	chan_t sa_f_c;
	chan_t sa_inv_c;
	chan_t fa3_c;
	prod_t sum_b_c, sum_g_c, sum_r_c;

	assign cfg_ready     = 1'b1;
	assign en            = ~valid_s9 | out_ready;
	assign in_ready      = en;
	assign out_valid     = valid_s9;
	assign blended_pixel = out_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paint_color_q <= '1;
		end else if (cfg_valid) begin
			paint_color_q <= paint_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// channel sums never exceed 255*255, so 16 bits hold them
	always_comb begin
		sa2_c    = d255(prod_s1);
		fa3_c    = sa_s2 + d255(wt_s2);
		sa_f_c   = (ctx_s7.fa == ALPHA_MAX) ? ctx_s7.sa : div_s7.quo;
		sa_inv_c = ALPHA_MAX - sa_f_c;
		sum_b_c  = ps_b_s8 + pd_b_s8;
		sum_g_c  = ps_g_s8 + pd_g_s8;
		sum_r_c  = ps_r_s8 + pd_r_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: coverage times paint alpha
			dest_s1   <= dest_pixel;
			opaque_s1 <= (coverage == ALPHA_MAX) && (paint_color_q[31:24] == ALPHA_MAX);
			prod_s1   <= {8'b0, coverage} * {8'b0, paint_color_q[31:24]};

			// s2: source alpha, weight of destination alpha
			opaque_s2   <= opaque_s1;
			sa_s2       <= sa2_c;
			wt_s2       <= {8'b0, ALPHA_MAX - sa2_c} * {8'b0, dest_s1[31:24]};
			dest_bgr_s2 <= dest_s1[23:0];

			// s3: result alpha, divider setup (sa * 255)
			ctx_s3.opaque   <= opaque_s2;
			ctx_s3.sa       <= sa_s2;
			ctx_s3.fa       <= fa3_c;
			ctx_s3.dest_bgr <= dest_bgr_s2;
			div_s3.rem      <= {sa_s2, 8'b0} - {8'b0, sa_s2};
			div_s3.quo      <= '0;

			// s4..s7: sa * 255 / fa
			ctx_s4 <= ctx_s3;
			div_s4 <= div2(div_s3, ctx_s3.fa, 3'd7);
			ctx_s5 <= ctx_s4;
			div_s5 <= div2(div_s4, ctx_s4.fa, 3'd5);
			ctx_s6 <= ctx_s5;
			div_s6 <= div2(div_s5, ctx_s5.fa, 3'd3);
			ctx_s7 <= ctx_s6;
			div_s7 <= div2(div_s6, ctx_s6.fa, 3'd1);

			// s8: channel products
			opaque_s8 <= ctx_s7.opaque;
			fa_s8     <= ctx_s7.fa;
			ps_b_s8   <= {8'b0, paint_color_q[23:16]} * {8'b0, sa_f_c};
			ps_g_s8   <= {8'b0, paint_color_q[15:8]}  * {8'b0, sa_f_c};
			ps_r_s8   <= {8'b0, paint_color_q[7:0]}   * {8'b0, sa_f_c};
			pd_b_s8   <= {8'b0, ctx_s7.dest_bgr[23:16]} * {8'b0, sa_inv_c};
			pd_g_s8   <= {8'b0, ctx_s7.dest_bgr[15:8]}  * {8'b0, sa_inv_c};
			pd_r_s8   <= {8'b0, ctx_s7.dest_bgr[7:0]}   * {8'b0, sa_inv_c};

			// s9: divide by 255 and pack
			if (opaque_s8) begin
				out_s9 <= paint_color_q;
			end else if (fa_s8 == '0) begin
				out_s9 <= '0;
			end else begin
				out_s9 <= {fa_s8, d255(sum_b_c), d255(sum_g_c), d255(sum_r_c)};
			end
		end
	end

`ifndef SYNTHESIS
	a_fa_covers_sa: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ctx_s3.fa >= ctx_s3.sa)
		else $error("result alpha below source alpha");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && (ctx_s7.fa != '0) |-> div_s7.rem < prod_t'(ctx_s7.fa))
		else $error("divider remainder not below divisor");

	a_opaque_copy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s8 && en && opaque_s8 |=> blended_pixel == paint_color_q)
		else $error("opaque full coverage did not pass paint color");
`endif

endmodule

`default_nettype wire
